>>> hdl/gauss_solve_3x3_top_defines.svh
// Assertion macros shared by the Gaussian elimination solver.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GAUSS_SOLVE_3X3_TOP_DEFINES_SVH
`define GAUSS_SOLVE_3X3_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GS3_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GS3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/gs3_pkg.sv
// Shared types, constants and saturation helper for the 3x3 solver.
// Depends on nothing; imported by every module of the solver but gs3_delay.
package gs3_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned DIV_STEPS  = 4;
   localparam int unsigned DIV_STAGES = WORD_W / DIV_STEPS;
   localparam int unsigned DIV_LAT    = DIV_STAGES + 2;
   localparam int unsigned MUL_LAT    = 2;

   typedef logic signed [WORD_W-1:0] fix_type;

   localparam fix_type FIX_MAX = 32'sh7fff_ffff;
   localparam fix_type FIX_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      fix_type    x1;
      fix_type    x2;
      fix_type    x3;
      status_type status;
   } result_type;

   typedef struct packed {
      fix_type value;
      logic    sat;
   } sat_fix_type;

   // Clamps a 33-bit signed value to the 32-bit range.
   function automatic sat_fix_type sat33(input logic signed [WORD_W:0] v);
      sat_fix_type r;
      r.sat   = v[WORD_W] != v[WORD_W-1];
      r.value = r.sat ? (v[WORD_W] ? FIX_MIN : FIX_MAX) : fix_type'(v[WORD_W-1:0]);
      return r;
   endfunction

endpackage

>>> hdl/gs3_delay.sv
// Enabled shift line that carries side data alongside the arithmetic units.
// Depends on nothing.
module gs3_delay #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule

>>> hdl/gs3_mulsub.sv
// Two-stage multiply, scale, saturate and subtract: minu - sat(a * b / 2^F).
// Depends on gs3_pkg.
module gs3_mulsub import gs3_pkg::*; #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    en,
   input  fix_type mul_a,
   input  fix_type mul_b,
   input  fix_type minu,
   output fix_type diff,
   output logic    sat
);

   localparam logic signed [2*WORD_W-1:0] ROUND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   logic signed [2*WORD_W-1:0] prod_ff;
   fix_type                    minu_ff;
   fix_type                    diff_ff;
   logic                       sat_ff;
   fix_type                    diff_in;
   logic                       sat_in;

   always_comb begin
      logic signed [2*WORD_W-1:0] scaled;
      logic                       mul_sat;
      fix_type                    mul_val;
      sat_fix_type                sub_res;
      // Adding 2^F - 1 before the arithmetic shift truncates toward zero.
      scaled  = (prod_ff + (prod_ff[2*WORD_W-1] ? ROUND : 64'sd0)) >>> FRAC_BITS;
      mul_sat = (scaled[2*WORD_W-1:WORD_W-1] != '0) && (scaled[2*WORD_W-1:WORD_W-1] != '1);
      mul_val = mul_sat ? (scaled[2*WORD_W-1] ? FIX_MIN : FIX_MAX)
                        : fix_type'(scaled[WORD_W-1:0]);
      sub_res = sat33(33'(minu_ff) - 33'(mul_val));
      diff_in = sub_res.value;
      sat_in  = sub_res.sat | mul_sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
         minu_ff <= minu;
         diff_ff <= diff_in;
         sat_ff  <= sat_in;
      end
   end

   assign diff = diff_ff;
   assign sat  = sat_ff;

endmodule

>>> hdl/gs3_div.sv
// Pipelined restoring divider: sat((num * 2^F) / den), truncated toward zero.
// Depends on gs3_pkg.
module gs3_div import gs3_pkg::*; #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    en,
   input  fix_type num,
   input  fix_type den,
   output fix_type quot,
   output logic    sat
);

   logic [WORD_W-1:0] rem_ff  [0:DIV_STAGES];
   logic [WORD_W-1:0] sh_ff   [0:DIV_STAGES];
   logic [WORD_W-1:0] den_ff  [0:DIV_STAGES];
   logic              neg_ff  [0:DIV_STAGES];
   logic              over_ff [0:DIV_STAGES];
   logic [WORD_W-1:0] rem_in  [0:DIV_STAGES];
   logic [WORD_W-1:0] sh_in   [0:DIV_STAGES];
   logic [WORD_W-1:0] den_in  [0:DIV_STAGES];
   logic              neg_in  [0:DIV_STAGES];
   logic              over_in [0:DIV_STAGES];
   fix_type           quot_ff;
   logic              sat_ff;
   fix_type           quot_in;
   logic              sat_in;

   always_comb begin
      logic [WORD_W-1:0] num_mag;
      logic [WORD_W-1:0] den_mag;
      logic [WORD_W-1:0] r;
      logic [WORD_W-1:0] q;
      logic [WORD_W:0]   t;
      num_mag = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
      den_mag = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
      // The scaled numerator is num_mag followed by F zeros. Its top F bits
      // seed the remainder; if they already reach the divisor, the quotient
      // needs more than 32 bits.
      rem_in[0]  = WORD_W'(num_mag[WORD_W-1 -: FRAC_BITS]);
      sh_in[0]   = {num_mag[WORD_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      den_in[0]  = den_mag;
      neg_in[0]  = num[WORD_W-1] ^ den[WORD_W-1];
      over_in[0] = WORD_W'(num_mag[WORD_W-1 -: FRAC_BITS]) >= den_mag;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = rem_ff[s];
         q = sh_ff[s];
         for (int k = 0; k < DIV_STEPS; k++) begin
            t = {r, q[WORD_W-1]};
            q = {q[WORD_W-2:0], 1'b0};
            if (t >= {1'b0, den_ff[s]}) begin
               t    = t - {1'b0, den_ff[s]};
               q[0] = 1'b1;
            end
            r = t[WORD_W-1:0];
         end
         rem_in[s+1]  = r;
         sh_in[s+1]   = q;
         den_in[s+1]  = den_ff[s];
         neg_in[s+1]  = neg_ff[s];
         over_in[s+1] = over_ff[s];
      end
   end

   always_comb begin
      logic [WORD_W-1:0] qm;
      qm = sh_ff[DIV_STAGES];
      if (over_ff[DIV_STAGES]) begin
         sat_in  = 1'b1;
         quot_in = neg_ff[DIV_STAGES] ? FIX_MIN : FIX_MAX;
      end else if (!neg_ff[DIV_STAGES]) begin
         sat_in  = qm[WORD_W-1];
         quot_in = qm[WORD_W-1] ? FIX_MAX : fix_type'(qm);
      end else begin
         sat_in  = qm > {1'b1, {(WORD_W-1){1'b0}}};
         quot_in = sat_in ? FIX_MIN : fix_type'(WORD_W'(-qm));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         sh_ff   <= sh_in;
         den_ff  <= den_in;
         neg_ff  <= neg_in;
         over_ff <= over_in;
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

>>> hdl/gauss_solve_3x3_top.sv
// Top level of the 3x3 Gaussian elimination solver (no pivoting, fixed point).
// Depends on gs3_pkg, gs3_div, gs3_mulsub, gs3_delay and the assertion header.
//
// Each request word carries a 3x3 coefficient matrix and a right-hand side in
// signed fixed point with FRAC_BITS fraction bits; each response word carries
// x1, x2, x3 and a status (ok, singular on a zero pivot with all unknowns zero,
// or saturated when any intermediate or final value was clamped). The solver
// is a fully pipelined datapath that accepts one word every clock cycle while
// req_stall is low. Its depth is set by three dependent division steps (each
// on 10-stage restoring dividers: an input stage, eight stages resolving four
// quotient bits apiece and an output stage) and five dependent
// multiply-subtract steps on units of two stages each. A two-entry output
// buffer decouples the response side: the pipeline keeps moving while a
// finished word waits, and it only holds (and raises req_stall) once both
// buffer entries are occupied.
`include "gauss_solve_3x3_top_defines.svh"

module gauss_solve_3x3_top import gs3_pkg::*; #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fix_type     req_a00,
   input  fix_type     req_a01,
   input  fix_type     req_a02,
   input  fix_type     req_a10,
   input  fix_type     req_a11,
   input  fix_type     req_a12,
   input  fix_type     req_a20,
   input  fix_type     req_a21,
   input  fix_type     req_a22,
   input  fix_type     req_rhs0,
   input  fix_type     req_rhs1,
   input  fix_type     req_rhs2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fix_type     rsp_sol_x1,
   output fix_type     rsp_sol_x2,
   output fix_type     rsp_sol_x3,
   output logic [1:0]  rsp_solve_status
);

   localparam int unsigned LAT = 3 * DIV_LAT + 5 * MUL_LAT;

   // The whole pipeline advances together; en is low only while the output
   // buffer is full.
   logic       en;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   result_type fifo_ff [2];
   result_type res_in;
   logic       push;
   logic       pop;

   assign en        = cnt_ff != 2'd2;
   assign req_stall = !en;

   // Stage A: row 0 divided by its pivot.
   fix_type r01_a, r02_a, y0_a;
   logic    sat_r01_a, sat_r02_a, sat_y0_a;

   gs3_div #(.FRAC_BITS(FRAC_BITS)) u_div_r01 (
      .clock(clock), .en(en), .num(req_a01), .den(req_a00), .quot(r01_a), .sat(sat_r01_a));
   gs3_div #(.FRAC_BITS(FRAC_BITS)) u_div_r02 (
      .clock(clock), .en(en), .num(req_a02), .den(req_a00), .quot(r02_a), .sat(sat_r02_a));
   gs3_div #(.FRAC_BITS(FRAC_BITS)) u_div_y0 (
      .clock(clock), .en(en), .num(req_rhs0), .den(req_a00), .quot(y0_a), .sat(sat_y0_a));

   fix_type a10_a, a11_a, a12_a, a20_a, a21_a, a22_a, rhs1_a, rhs2_a;
   logic    zero0_a;
   logic [8*WORD_W:0] dly_a_out;

   gs3_delay #(.WIDTH(8*WORD_W+1), .DEPTH(DIV_LAT)) u_dly_a (
      .clock(clock), .en(en),
      .din({req_a10, req_a11, req_a12, req_a20, req_a21, req_a22, req_rhs1, req_rhs2,
            req_a00 == '0}),
      .dout(dly_a_out));
   assign {a10_a, a11_a, a12_a, a20_a, a21_a, a22_a, rhs1_a, rhs2_a, zero0_a} = dly_a_out;

   // Stage B: row 0 eliminated from rows 1 and 2.
   fix_type m11_b, m12_b, z1_b, m21_b, m22_b, z2_b;
   logic    sat_m11_b, sat_m12_b, sat_z1_b, sat_m21_b, sat_m22_b, sat_z2_b;

   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_m11 (.clock(clock), .en(en),
      .mul_a(r01_a), .mul_b(a10_a), .minu(a11_a), .diff(m11_b), .sat(sat_m11_b));
   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_m12 (.clock(clock), .en(en),
      .mul_a(r02_a), .mul_b(a10_a), .minu(a12_a), .diff(m12_b), .sat(sat_m12_b));
   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_z1 (.clock(clock), .en(en),
      .mul_a(y0_a), .mul_b(a10_a), .minu(rhs1_a), .diff(z1_b), .sat(sat_z1_b));
   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_m21 (.clock(clock), .en(en),
      .mul_a(r01_a), .mul_b(a20_a), .minu(a21_a), .diff(m21_b), .sat(sat_m21_b));
   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_m22 (.clock(clock), .en(en),
      .mul_a(r02_a), .mul_b(a20_a), .minu(a22_a), .diff(m22_b), .sat(sat_m22_b));
   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_z2 (.clock(clock), .en(en),
      .mul_a(y0_a), .mul_b(a20_a), .minu(rhs2_a), .diff(z2_b), .sat(sat_z2_b));

   fix_type r01_b, r02_b, y0_b;
   logic    zero0_b, sat_a_b, sing_b, sat_b;
   logic [3*WORD_W+1:0] dly_b_out;

   gs3_delay #(.WIDTH(3*WORD_W+2), .DEPTH(MUL_LAT)) u_dly_b (
      .clock(clock), .en(en),
      .din({r01_a, r02_a, y0_a, zero0_a, sat_r01_a | sat_r02_a | sat_y0_a}),
      .dout(dly_b_out));
   assign {r01_b, r02_b, y0_b, zero0_b, sat_a_b} = dly_b_out;

   assign sing_b = zero0_b | (m11_b == '0);
   assign sat_b  = sat_a_b | sat_m11_b | sat_m12_b | sat_z1_b | sat_m21_b | sat_m22_b
                 | sat_z2_b;

   // Stage C: new row 1 divided by its pivot.
   fix_type r12_c, y1_c;
   logic    sat_r12_c, sat_y1_c;

   gs3_div #(.FRAC_BITS(FRAC_BITS)) u_div_r12 (
      .clock(clock), .en(en), .num(m12_b), .den(m11_b), .quot(r12_c), .sat(sat_r12_c));
   gs3_div #(.FRAC_BITS(FRAC_BITS)) u_div_y1 (
      .clock(clock), .en(en), .num(z1_b), .den(m11_b), .quot(y1_c), .sat(sat_y1_c));

   fix_type m21_c, m22_c, z2_c, r01_c, r02_c, y0_c;
   logic    sing_c, sat_b_c, sat_c;
   logic [6*WORD_W+1:0] dly_c_out;

   gs3_delay #(.WIDTH(6*WORD_W+2), .DEPTH(DIV_LAT)) u_dly_c (
      .clock(clock), .en(en),
      .din({m21_b, m22_b, z2_b, r01_b, r02_b, y0_b, sing_b, sat_b}),
      .dout(dly_c_out));
   assign {m21_c, m22_c, z2_c, r01_c, r02_c, y0_c, sing_c, sat_b_c} = dly_c_out;
   assign sat_c = sat_b_c | sat_r12_c | sat_y1_c;

   // Stage D: new row 1 eliminated from row 2.
   fix_type n22_d, w2_d;
   logic    sat_n22_d, sat_w2_d;

   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_n22 (.clock(clock), .en(en),
      .mul_a(r12_c), .mul_b(m21_c), .minu(m22_c), .diff(n22_d), .sat(sat_n22_d));
   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_w2 (.clock(clock), .en(en),
      .mul_a(y1_c), .mul_b(m21_c), .minu(z2_c), .diff(w2_d), .sat(sat_w2_d));

   fix_type r12_d, y1_d, r01_d, r02_d, y0_d;
   logic    sing_c_d, sat_c_d, sing_d, sat_d;
   logic [5*WORD_W+1:0] dly_d_out;

   gs3_delay #(.WIDTH(5*WORD_W+2), .DEPTH(MUL_LAT)) u_dly_d (
      .clock(clock), .en(en),
      .din({r12_c, y1_c, r01_c, r02_c, y0_c, sing_c, sat_c}),
      .dout(dly_d_out));
   assign {r12_d, y1_d, r01_d, r02_d, y0_d, sing_c_d, sat_c_d} = dly_d_out;
   assign sing_d = sing_c_d | (n22_d == '0);
   assign sat_d  = sat_c_d | sat_n22_d | sat_w2_d;

   // Stage E: last pivot gives x3.
   fix_type x3_e;
   logic    sat_x3_e;

   gs3_div #(.FRAC_BITS(FRAC_BITS)) u_div_x3 (
      .clock(clock), .en(en), .num(w2_d), .den(n22_d), .quot(x3_e), .sat(sat_x3_e));

   fix_type r12_e, y1_e, r01_e, r02_e, y0_e;
   logic    sing_e, sat_d_e, sat_e;
   logic [5*WORD_W+1:0] dly_e_out;

   gs3_delay #(.WIDTH(5*WORD_W+2), .DEPTH(DIV_LAT)) u_dly_e (
      .clock(clock), .en(en),
      .din({r12_d, y1_d, r01_d, r02_d, y0_d, sing_d, sat_d}),
      .dout(dly_e_out));
   assign {r12_e, y1_e, r01_e, r02_e, y0_e, sing_e, sat_d_e} = dly_e_out;
   assign sat_e = sat_d_e | sat_x3_e;

   // Stage F: back-substitution for x2.
   fix_type x2_f;
   logic    sat_x2_f;

   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_x2 (.clock(clock), .en(en),
      .mul_a(r12_e), .mul_b(x3_e), .minu(y1_e), .diff(x2_f), .sat(sat_x2_f));

   fix_type x3_f, r01_f, r02_f, y0_f;
   logic    sing_f, sat_e_f, sat_f;
   logic [4*WORD_W+1:0] dly_f_out;

   gs3_delay #(.WIDTH(4*WORD_W+2), .DEPTH(MUL_LAT)) u_dly_f (
      .clock(clock), .en(en),
      .din({x3_e, r01_e, r02_e, y0_e, sing_e, sat_e}),
      .dout(dly_f_out));
   assign {x3_f, r01_f, r02_f, y0_f, sing_f, sat_e_f} = dly_f_out;
   assign sat_f = sat_e_f | sat_x2_f;

   // Stage G: first half of x1, y0 - r01 * x2.
   fix_type t1_g;
   logic    sat_t1_g;

   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_t1 (.clock(clock), .en(en),
      .mul_a(r01_f), .mul_b(x2_f), .minu(y0_f), .diff(t1_g), .sat(sat_t1_g));

   fix_type x3_g, r02_g, x2_g;
   logic    sing_g, sat_f_g, sat_g;
   logic [3*WORD_W+1:0] dly_g_out;

   gs3_delay #(.WIDTH(3*WORD_W+2), .DEPTH(MUL_LAT)) u_dly_g (
      .clock(clock), .en(en),
      .din({x3_f, r02_f, x2_f, sing_f, sat_f}),
      .dout(dly_g_out));
   assign {x3_g, r02_g, x2_g, sing_g, sat_f_g} = dly_g_out;
   assign sat_g = sat_f_g | sat_t1_g;

   // Stage H: x1 completed by subtracting r02 * x3.
   fix_type x1_h;
   logic    sat_x1_h;

   gs3_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_x1 (.clock(clock), .en(en),
      .mul_a(r02_g), .mul_b(x3_g), .minu(t1_g), .diff(x1_h), .sat(sat_x1_h));

   fix_type x2_h, x3_h;
   logic    sing_h, sat_g_h;
   logic [2*WORD_W+1:0] dly_h_out;

   gs3_delay #(.WIDTH(2*WORD_W+2), .DEPTH(MUL_LAT)) u_dly_h (
      .clock(clock), .en(en),
      .din({x2_g, x3_g, sing_g, sat_g}),
      .dout(dly_h_out));
   assign {x2_h, x3_h, sing_h, sat_g_h} = dly_h_out;

   // A zero pivot anywhere overrides saturation and forces zero unknowns.
   always_comb begin
      if (sing_h) begin
         res_in.x1     = '0;
         res_in.x2     = '0;
         res_in.x3     = '0;
         res_in.status = STATUS_SINGULAR;
      end else begin
         res_in.x1     = x1_h;
         res_in.x2     = x2_h;
         res_in.x3     = x3_h;
         res_in.status = (sat_g_h | sat_x1_h) ? STATUS_SATURATED : STATUS_OK;
      end
   end

   // Valid bits travel with the data through every stage.
   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Two-entry output buffer.
   assign push = en & vld_ff[LAT-1];
   assign pop  = (cnt_ff != 2'd0) & !rsp_stall;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res_in;
      end
   end

   assign rsp_valid        = cnt_ff != 2'd0;
   assign rsp_sol_x1       = fifo_ff[rd_ptr_ff].x1;
   assign rsp_sol_x2       = fifo_ff[rd_ptr_ff].x2;
   assign rsp_sol_x3       = fifo_ff[rd_ptr_ff].x3;
   assign rsp_solve_status = fifo_ff[rd_ptr_ff].status;

   // A singular answer must never show nonzero unknowns.
   `GS3_ASSERT_SAME(a_singular_zero, clock, reset,
      rsp_valid && rsp_solve_status == STATUS_SINGULAR,
      rsp_sol_x1 == '0 && rsp_sol_x2 == '0 && rsp_sol_x3 == '0,
      "singular answer carries nonzero unknowns")
   // A push without a pop grows the buffer by exactly one word.
   `GS3_ASSERT_NEXT(a_fill_count, clock, reset, push && !pop,
      cnt_ff == $past(cnt_ff) + 2'd1, "output buffer count out of step with push")
   // While held, no valid bit may move through the pipeline.
   `GS3_ASSERT_NEXT(a_hold_pipe, clock, reset, !en, vld_ff == $past(vld_ff),
      "pipeline moved while held")

endmodule

>>> verif/tb_gauss_solve_3x3_top.sv
// Self-checking testbench for the 3x3 Gaussian elimination solver.
// Depends on gs3_pkg and gauss_solve_3x3_top with the modules that it instantiates.
module tb_gauss_solve_3x3_top import gs3_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Fraction bits of the fixed-point format, matched to the instance below.
   localparam int unsigned FRAC    = 16;
   localparam int unsigned N_DIR   = 13;
   localparam int unsigned N_RAND  = 1240;
   localparam int unsigned IDLE_LIMIT = 5000;

   // One linear system, in the order a00..a22, rhs0..rhs2.
   typedef fix_type system_type [12];

   localparam fix_type ONE = 32'sh0001_0000;
   localparam fix_type LSB_NEG = 32'shFFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   fix_type req_word [12];
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   fix_type rsp_sol_x1, rsp_sol_x2, rsp_sol_x3;
   logic [1:0] rsp_solve_status;

   // Solutions that have been requested and not yet returned, oldest first.
   result_type pending_solutions [$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;

   initial begin
      for (int i = 0; i < 12; i++) begin
         req_word[i] = '0;
      end
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   gauss_solve_3x3_top #(.FRAC_BITS(FRAC)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_a00          (req_word[0]),
      .req_a01          (req_word[1]),
      .req_a02          (req_word[2]),
      .req_a10          (req_word[3]),
      .req_a11          (req_word[4]),
      .req_a12          (req_word[5]),
      .req_a20          (req_word[6]),
      .req_a21          (req_word[7]),
      .req_a22          (req_word[8]),
      .req_rhs0         (req_word[9]),
      .req_rhs1         (req_word[10]),
      .req_rhs2         (req_word[11]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sol_x1       (rsp_sol_x1),
      .rsp_sol_x2       (rsp_sol_x2),
      .rsp_sol_x3       (rsp_sol_x3),
      .rsp_solve_status (rsp_solve_status)
   );

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic of the solver. Every step works on exact 64-bit
   // values and clamps the outcome to 32 bits, raising the saturation flag
   // whenever the clamp actually changes something.
   // ---------------------------------------------------------------------
   function automatic longint clamp32(input longint v, inout bit sat);
      if (v > longint'(FIX_MAX)) begin
         sat = 1'b1;
         return longint'(FIX_MAX);
      end
      if (v < longint'(FIX_MIN)) begin
         sat = 1'b1;
         return longint'(FIX_MIN);
      end
      return v;
   endfunction

   // Product scaled down by the fraction bits, truncated toward zero.
   function automatic longint fix_mul(input longint a, input longint b, inout bit sat);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0 ? -p : p) >>> FRAC;
      return clamp32(p < 0 ? -m : m, sat);
   endfunction

   // Numerator scaled up by the fraction bits, divided, truncated toward zero.
   function automatic longint fix_div(input longint n, input longint d, inout bit sat);
      longint q;
      q = ((n < 0 ? -n : n) <<< FRAC) / (d < 0 ? -d : d);
      return clamp32(((n < 0) != (d < 0)) ? -q : q, sat);
   endfunction

   function automatic longint fix_sub(input longint a, input longint b, inout bit sat);
      return clamp32(a - b, sat);
   endfunction

   // Solves one system by elimination without pivoting, in the block's order.
   function automatic result_type solve_system(input system_type s);
      result_type r;
      bit sat;
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2;
      longint r01, r02, y0, m11, m12, z1, m21, m22, z2, r12, y1, n22, w2;
      longint x1, x2, x3;
      sat = 1'b0;
      r.x1 = '0;
      r.x2 = '0;
      r.x3 = '0;
      r.status = STATUS_SINGULAR;
      a00 = s[0]; a01 = s[1]; a02 = s[2];
      a10 = s[3]; a11 = s[4]; a12 = s[5];
      a20 = s[6]; a21 = s[7]; a22 = s[8];
      b0 = s[9]; b1 = s[10]; b2 = s[11];
      if (a00 == 0) begin
         return r;
      end
      r01 = fix_div(a01, a00, sat);
      r02 = fix_div(a02, a00, sat);
      y0  = fix_div(b0, a00, sat);
      m11 = fix_sub(a11, fix_mul(r01, a10, sat), sat);
      m12 = fix_sub(a12, fix_mul(r02, a10, sat), sat);
      z1  = fix_sub(b1, fix_mul(y0, a10, sat), sat);
      m21 = fix_sub(a21, fix_mul(r01, a20, sat), sat);
      m22 = fix_sub(a22, fix_mul(r02, a20, sat), sat);
      z2  = fix_sub(b2, fix_mul(y0, a20, sat), sat);
      if (m11 == 0) begin
         return r;
      end
      r12 = fix_div(m12, m11, sat);
      y1  = fix_div(z1, m11, sat);
      n22 = fix_sub(m22, fix_mul(r12, m21, sat), sat);
      w2  = fix_sub(z2, fix_mul(y1, m21, sat), sat);
      if (n22 == 0) begin
         return r;
      end
      x3 = fix_div(w2, n22, sat);
      x2 = fix_sub(y1, fix_mul(r12, x3, sat), sat);
      x1 = fix_sub(y0, fix_mul(r01, x2, sat), sat);
      x1 = fix_sub(x1, fix_mul(r02, x3, sat), sat);
      r.x1 = fix_type'(x1);
      r.x2 = fix_type'(x2);
      r.x3 = fix_type'(x3);
      r.status = sat ? STATUS_SATURATED : STATUS_OK;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed systems. Rows whose answer is obvious carry it typed in; the
   // rest are checked against the predictor like the random words.
   // ---------------------------------------------------------------------
   localparam fix_type DIR_SYS [N_DIR][12] = '{
      // Identity matrix: the answer is the right-hand side itself.
      '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE,
        32'sh0003_0000, 32'shFFFB_0000, 32'sh0007_0000},
      // Zero first pivot with everything else at the top of the range.
      '{0, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
        FIX_MAX, FIX_MAX, FIX_MAX},
      // Zero first pivot with everything else at the bottom of the range.
      '{0, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
        FIX_MIN, FIX_MIN, FIX_MIN},
      // All fields at the extremes.
      '{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
        FIX_MAX, FIX_MAX, FIX_MAX},
      '{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
        FIX_MIN, FIX_MIN, FIX_MIN},
      // Second pivot vanishes: row 1 is twice row 0 in its first two columns.
      '{ONE, 32'sh0002_0000, 32'sh0003_0000, 32'sh0002_0000, 32'sh0004_0000,
        32'sh0005_0000, 0, 0, ONE, ONE, ONE, ONE},
      // Third pivot vanishes: row 2 is the sum of rows 0 and 1.
      '{ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE, 32'sh0002_0000},
      // Tiny first pivot forces the ratios to saturate.
      '{32'sh0000_0001, FIX_MAX, FIX_MIN, ONE, ONE, ONE, ONE, ONE, ONE,
        FIX_MAX, 0, 0},
      '{LSB_NEG, ONE, LSB_NEG, 0, ONE, 0, 0, 0, ONE, FIX_MIN, FIX_MAX, LSB_NEG},
      '{32'sh0002_0000, 32'sh0000_8000, 0, 32'shFFFF_8000, 32'sh0002_0000,
        32'sh0000_4000, 0, 32'sh0000_8000, 32'sh0002_0000,
        32'shFFFE_8000, 32'sh0001_2345, 32'shFFF0_0000},
      '{FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX,
        FIX_MIN, FIX_MAX, FIX_MIN},
      '{LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG,
        LSB_NEG, LSB_NEG, LSB_NEG},
      '{FIX_MAX, 0, 0, 0, FIX_MAX, 0, 0, 0, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN}
   };

   localparam bit DIR_TYPED [N_DIR] = '{1, 1, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0};

   localparam result_type DIR_ANSWER [N_DIR] = '{
      '{32'sh0003_0000, 32'shFFFB_0000, 32'sh0007_0000, STATUS_OK},
      '{0, 0, 0, STATUS_SINGULAR},
      '{0, 0, 0, STATUS_SINGULAR},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_SINGULAR},
      '{0, 0, 0, STATUS_SINGULAR},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_OK},
      '{0, 0, 0, STATUS_OK}
   };

   // ---------------------------------------------------------------------
   // Random systems. Most are well-conditioned so that the solve runs all
   // the way through; the rest reach the singular and saturating corners.
   // ---------------------------------------------------------------------
   function automatic fix_type rand_span(input int unsigned span);
      return fix_type'(int'($urandom_range(0, 2 * span)) - int'(span));
   endfunction

   function automatic fix_type rand_corner();
      case ($urandom_range(0, 5))
         0: return FIX_MAX;
         1: return FIX_MIN;
         2: return '0;
         3: return 32'sh0000_0001;
         4: return LSB_NEG;
         default: return fix_type'($urandom);
      endcase
   endfunction

   function automatic system_type random_system();
      system_type s;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      for (int i = 0; i < 12; i++) begin
         if (pick < 60) begin
            // Diagonal near a random integer of 1 to 8 in either sign, random fractions elsewhere.
            if (i == 0 || i == 4 || i == 8) begin
               s[i] = fix_type'($urandom_range(1, 8) << FRAC) + rand_span(32'hFFFF);
               if ($urandom_range(0, 1)) begin
                  s[i] = -s[i];
               end
            end else if (i < 9) begin
               s[i] = rand_span(32'h0002_0000);
            end else begin
               s[i] = rand_span(32'h0100_0000);
            end
         end else if (pick < 75) begin
            s[i] = fix_type'($urandom);
         end else if (pick < 90) begin
            // Small integers make the pivots vanish often.
            s[i] = fix_type'(int'($urandom_range(0, 4)) - 2) <<< FRAC;
         end else begin
            s[i] = rand_corner();
         end
      end
      if (pick >= 60 && pick < 65) begin
         s[0] = '0;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid is only dropped when a gap is wanted, so that
   // back-to-back words keep it high without a second assignment.
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_system(input system_type s, input result_type answer);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      for (int i = 0; i < 12; i++) begin
         req_word[i] <= s[i];
      end
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_solutions.push_back(answer);
   endtask

   // ---------------------------------------------------------------------
   // Response side stall: alternating bursts, mostly short, a few long,
   // with stretches of no stall at all.
   // ---------------------------------------------------------------------
   int unsigned stall_left = 0;
   bit          stall_level = 1'b0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_level = !stall_level;
         if (!stall_level) begin
            stall_left = $urandom_range(1, 30);
         end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(30, 80);
         end else begin
            stall_left = $urandom_range(1, 3);
         end
      end
      stall_left = stall_left - 1;
      rsp_stall <= reset ? 1'b0 : stall_level;
   end

   // ---------------------------------------------------------------------
   // Checker: each accepted response word is compared with the oldest
   // pending solution, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_solutions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response word with no request pending", $realtime);
            end
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_sol_x1 !== want.x1 || rsp_sol_x2 !== want.x2 ||
                rsp_sol_x3 !== want.x3 || rsp_solve_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected x1=%h x2=%h x3=%h status=%0d",
                           $realtime, want.x1, want.x2, want.x3, want.status);
                  $display("%0t: actual   x1=%h x2=%h x3=%h status=%0d",
                           $realtime, rsp_sol_x1, rsp_sol_x2, rsp_sol_x3,
                           rsp_solve_status);
               end
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      system_type sys;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         sys = DIR_SYS[i];
         send_system(sys, DIR_TYPED[i] ? DIR_ANSWER[i] : solve_system(sys));
      end

      for (int i = 0; i < N_RAND; i++) begin
         // Midway, let the pipeline drain completely before going on.
         if (i == N_RAND / 2) begin
            req_valid <= 1'b0;
            while (pending_solutions.size() != 0) begin
               @(posedge clock);
            end
         end
         sys = random_system();
         send_system(sys, solve_system(sys));
      end
      req_valid <= 1'b0;

      while (pending_solutions.size() != 0) begin
         @(posedge clock);
      end
      // Latency of the pipeline plus margin, to catch any extra words.
      repeat (60) @(posedge clock);

      if (mismatches == 0 && pending_solutions.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> gauss_solve_3x3_top.f
+incdir+hdl
hdl/gs3_pkg.sv
hdl/gs3_delay.sv
hdl/gs3_mulsub.sv
hdl/gs3_div.sv
hdl/gauss_solve_3x3_top.sv
verif/tb_gauss_solve_3x3_top.sv
